>>> src/art_pkg.sv
// Shared types and constants for the ARP resolution table.
// No dependencies; used by arp_resolution_table_core and the bench.
package art_pkg;

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_ARP  = 2'd1;
  localparam logic [1:0] OP_IPV4 = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [1:0] KIND_IPV4    = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_REPLY   = 2'd2;
  localparam logic [1:0] KIND_DELIVER = 2'd3;

  localparam logic [1:0] REG_OWN_MAC = 2'd0;
  localparam logic [1:0] REG_OWN_IP  = 2'd1;
  localparam logic [1:0] REG_HOLD    = 2'd2;
  localparam logic [1:0] REG_LIFE    = 2'd3;

  localparam logic [14:0] HOLD_RESET = 15'd5000;
  localparam logic [14:0] LIFE_RESET = 15'd30000;
  localparam logic [47:0] MAC_BCAST  = 48'hFFFF_FFFF_FFFF;

  // One table entry as stored in RAM (valid bit kept in flops).
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic        resolved;
    logic [14:0] time_left;
    logic        has_waiting;
    logic [15:0] waiting_handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] dst;
    logic [31:0] tip;
    logic [47:0] tmac;
    logic [15:0] handle;
  } result_t;

endpackage

>>> src/art_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/arp_resolution_table_core.sv
// Top level of the ARP resolution table: sequencer, entry RAM, valid flops.
// Depends on art_pkg and art_ram.
//
// Usage:
//  - Command channel: an item (operation plus fields) is taken when start is
//    high and busy is low. busy stays high until the item is fully handled.
//  - Results: each result sits on the result ports for one cycle with
//    result_valid high; last_result marks the final one of an item. The
//    receiver cannot stall, so results never wait.
//  - Config: cfg_we/cfg_index/cfg_data write own_mac, own_ip,
//    request_hold_ms, entry_life_ms; write only while busy is low.
//  - Timing: send, ARP and tick items sweep the table once through the entry
//    RAM, one slot per cycle (one read port, registered read). busy stays
//    high for the sweep on a tick; a send or ARP item adds the S_FINISH
//    state, and an ARP item that gives two results adds S_EMIT2 as well.
//    The first result is registered in S_FINISH and a second one in S_EMIT2,
//    right after it. An IPv4 item needs no sweep: busy stays low, its result
//    shows in the next cycle and another item can be taken at once. The slot
//    sweep is what sets the rate.
//  - Reset: valid flops clear at once (no clearing pass), config registers
//    return to their reset values; RAM contents are only used for slots
//    whose valid flop is set.
//  - Lookup result (match / lowest free slot) is known after the sweep; the
//    write-back then happens in S_FINISH using a copy of the hit slot held
//    in a register from the sweep.
module arp_resolution_table_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] peer_ip,
  input  logic [47:0] sender_mac,
  input  logic [47:0] frame_dst_mac,
  input  logic [31:0] asked_ip,
  input  logic        arp_is_request,
  input  logic        parse_ok,
  input  logic [15:0] datagram_handle,
  input  logic [15:0] elapsed_ms,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output logic        result_valid,
  output logic [1:0]  frame_kind,
  output logic [47:0] dest_mac,
  output logic [31:0] arp_target_ip,
  output logic [47:0] arp_target_mac,
  output logic [15:0] out_handle,
  output logic        last_result
);
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_IDX = CW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FINISH, S_EMIT2
  } state_t;

  state_t state;

  logic [47:0] own_mac;
  logic [31:0] own_ip;
  logic [14:0] hold_ms;
  logic [14:0] life_ms;

  // latched item
  logic [1:0]  op;
  logic [31:0] ip_q;
  logic [47:0] smac_q;
  logic [31:0] asked_q;
  logic        req_q;
  logic        ok_q;
  logic [15:0] handle_q;
  logic [15:0] elapsed_q;

  logic [TABLE_ENTRIES-1:0] valid;

  // sweep control
  logic [CW-1:0] rd_idx;     // address being issued
  logic          rd_pend;    // data for chk_idx arrives this cycle
  logic [AW-1:0] chk_idx;
  logic          hit;
  logic [AW-1:0] hit_idx;
  art_pkg::entry_t hit_ent;
  logic          has_free;
  logic [AW-1:0] free_idx;

  logic          we;
  logic [AW-1:0] waddr;
  art_pkg::entry_t wdata;
  art_pkg::entry_t rdata;

  art_pkg::result_t res2;   // queued second result

  art_ram #(.WIDTH(art_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_idx[AW-1:0]),
    .rdata(rdata)
  );

  assign busy = (state != S_IDLE);

  // tick write-back happens during the sweep, one slot per cycle
  logic chk_valid;
  logic tick_alive;
  assign chk_valid  = rd_pend && valid[chk_idx];
  assign tick_alive = {1'b0, rdata.time_left} > elapsed_q;

  always_comb begin
    we    = 1'b0;
    waddr = chk_idx;
    wdata = rdata;
    if (state == S_SCAN && op == art_pkg::OP_TICK && chk_valid && tick_alive) begin
      we             = 1'b1;
      wdata.time_left = 15'(({1'b0, rdata.time_left} - elapsed_q));
    end else if (state == S_FINISH) begin
      waddr = hit ? hit_idx : free_idx;
      if (op == art_pkg::OP_SEND && !hit && has_free) begin
        we                   = 1'b1;
        wdata.ip             = ip_q;
        wdata.mac            = '0;
        wdata.resolved       = 1'b0;
        wdata.time_left      = hold_ms;
        wdata.has_waiting    = 1'b1;
        wdata.waiting_handle = handle_q;
      end else if (op == art_pkg::OP_ARP && ok_q && (hit || has_free)) begin
        we                   = 1'b1;
        wdata.ip             = ip_q;
        wdata.mac            = smac_q;
        wdata.resolved       = 1'b1;
        wdata.time_left      = life_ms;
        wdata.has_waiting    = 1'b0;
        wdata.waiting_handle = hit ? hit_ent.waiting_handle : 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      own_mac      <= '0;
      own_ip       <= '0;
      hold_ms      <= art_pkg::HOLD_RESET;
      life_ms      <= art_pkg::LIFE_RESET;
      valid        <= '0;
      result_valid <= 1'b0;
      last_result  <= 1'b0;
      rd_pend      <= 1'b0;
      rd_idx       <= '0;
    end else begin
      result_valid <= 1'b0;
      last_result  <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          art_pkg::REG_OWN_MAC: own_mac <= cfg_data;
          art_pkg::REG_OWN_IP:  own_ip  <= cfg_data[31:0];
          art_pkg::REG_HOLD:    hold_ms <= cfg_data[14:0];
          art_pkg::REG_LIFE:    life_ms <= cfg_data[14:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op        <= operation;
            ip_q      <= peer_ip;
            smac_q    <= sender_mac;
            asked_q   <= asked_ip;
            req_q     <= arp_is_request;
            ok_q      <= parse_ok;
            handle_q  <= datagram_handle;
            elapsed_q <= elapsed_ms;
            hit       <= 1'b0;
            has_free  <= 1'b0;
            hit_idx   <= '0;
            free_idx  <= '0;
            rd_idx    <= '0;
            rd_pend   <= 1'b0;
            if (operation == art_pkg::OP_IPV4) begin
              if (parse_ok && frame_dst_mac == own_mac) begin
                result_valid   <= 1'b1;
                last_result    <= 1'b1;
                frame_kind     <= art_pkg::KIND_DELIVER;
                dest_mac       <= '0;
                arp_target_ip  <= '0;
                arp_target_mac <= '0;
                out_handle     <= datagram_handle;
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // issue next address, check returned slot
          rd_pend <= (rd_idx <= LAST_IDX);
          chk_idx <= rd_idx[AW-1:0];
          if (rd_idx <= LAST_IDX) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (rd_pend) begin
            if (op == art_pkg::OP_TICK) begin
              if (chk_valid && !tick_alive) begin
                valid[chk_idx] <= 1'b0;
              end
            end else begin
              if (chk_valid && rdata.ip == ip_q && !hit) begin
                hit     <= 1'b1;
                hit_idx <= chk_idx;
                hit_ent <= rdata;
              end
              if (!valid[chk_idx] && !has_free) begin
                has_free <= 1'b1;
                free_idx <= chk_idx;
              end
            end
          end
          if (rd_pend && chk_idx == LAST_IDX[AW-1:0]) begin
            state <= (op == art_pkg::OP_TICK) ? S_IDLE : S_FINISH;
          end
        end
        S_FINISH: begin
          state <= S_IDLE;
          dest_mac       <= '0;
          arp_target_ip  <= '0;
          arp_target_mac <= '0;
          out_handle     <= '0;
          if (op == art_pkg::OP_SEND) begin
            if (hit) begin
              if (hit_ent.resolved) begin
                result_valid <= 1'b1;
                last_result  <= 1'b1;
                frame_kind   <= art_pkg::KIND_IPV4;
                dest_mac     <= hit_ent.mac;
                out_handle   <= handle_q;
              end
            end else begin
              result_valid  <= 1'b1;
              last_result   <= 1'b1;
              frame_kind    <= art_pkg::KIND_REQUEST;
              dest_mac      <= art_pkg::MAC_BCAST;
              arp_target_ip <= ip_q;
              if (has_free) begin
                valid[free_idx] <= 1'b1;
              end
            end
          end else if (op == art_pkg::OP_ARP && ok_q) begin
            if (!hit && has_free) begin
              valid[free_idx] <= 1'b1;
            end
            res2.kind   <= art_pkg::KIND_REPLY;
            res2.dst    <= smac_q;
            res2.tip    <= ip_q;
            res2.tmac   <= smac_q;
            res2.handle <= '0;
            if (hit && hit_ent.has_waiting) begin
              result_valid <= 1'b1;
              frame_kind   <= art_pkg::KIND_IPV4;
              dest_mac     <= smac_q;
              out_handle   <= hit_ent.waiting_handle;
              if (req_q && asked_q == own_ip) begin
                state <= S_EMIT2;
              end else begin
                last_result <= 1'b1;
              end
            end else if (req_q && asked_q == own_ip) begin
              result_valid   <= 1'b1;
              last_result    <= 1'b1;
              frame_kind     <= art_pkg::KIND_REPLY;
              dest_mac       <= smac_q;
              arp_target_ip  <= ip_q;
              arp_target_mac <= smac_q;
            end
          end
        end
        S_EMIT2: begin
          result_valid   <= 1'b1;
          last_result    <= 1'b1;
          frame_kind     <= res2.kind;
          dest_mac       <= res2.dst;
          arp_target_ip  <= res2.tip;
          arp_target_mac <= res2.tmac;
          out_handle     <= res2.handle;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result strobes are well formed, a taken non-IPv4 item makes the block busy, RAM writes only in S_SCAN/S_FINISH
  a_last_implies_valid: assert property (@(posedge clk) disable iff (rst)
    last_result |-> result_valid) else $error("last without valid");
  a_emit2_follows: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT2 |-> result_valid && !last_result)
    else $error("second result without first");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && operation != art_pkg::OP_IPV4) |=> busy)
    else $error("item not taken");
  a_write_scan: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_SCAN || state == S_FINISH))
    else $error("stray RAM write");
endmodule

>>> bench/tb_arp_resolution_table_core.sv
// Self-checking bench for arp_resolution_table_core: directed rows, then random traffic.
// Depends on art_pkg and the RTL in src; a built-in predictor supplies expected frames.
module tb_arp_resolution_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = 16;
  localparam int IP_POOL   = 24;
  localparam int IDLE_MAX  = 3000;  // sweep + gap + config pause, many times over
  localparam int SETTLE    = SLOTS + 8;

  // One command item as driven on the ports.
  typedef struct {
    logic [1:0]  op;
    logic [31:0] peer;
    logic [47:0] smac;
    logic [47:0] fdst;
    logic [31:0] asked;
    logic        is_req;
    logic        ok;
    logic [15:0] hdl;
    logic [15:0] elapsed;
  } cmd_t;

  // One outgoing frame/delivery as seen on the result ports.
  typedef struct {
    art_pkg::result_t r;
    logic             last;
  } frame_t;

  // Directed row: when fixed is set, the typed result (or none) replaces the prediction.
  typedef struct {
    cmd_t   c;
    bit     fixed;
    bit     has_res;
    frame_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation = '0;
  logic [31:0] peer_ip = '0;
  logic [47:0] sender_mac = '0;
  logic [47:0] frame_dst_mac = '0;
  logic [31:0] asked_ip = '0;
  logic        arp_is_request = 1'b0;
  logic        parse_ok = 1'b0;
  logic [15:0] datagram_handle = '0;
  logic [15:0] elapsed_ms = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic        result_valid;
  logic [1:0]  frame_kind;
  logic [47:0] dest_mac;
  logic [31:0] arp_target_ip;
  logic [47:0] arp_target_mac;
  logic [15:0] out_handle;
  logic        last_result;

  arp_resolution_table_core #(.TABLE_ENTRIES(SLOTS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .peer_ip(peer_ip), .sender_mac(sender_mac),
    .frame_dst_mac(frame_dst_mac), .asked_ip(asked_ip),
    .arp_is_request(arp_is_request), .parse_ok(parse_ok),
    .datagram_handle(datagram_handle), .elapsed_ms(elapsed_ms),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .frame_kind(frame_kind), .dest_mac(dest_mac),
    .arp_target_ip(arp_target_ip), .arp_target_mac(arp_target_mac),
    .out_handle(out_handle), .last_result(last_result)
  );

  always #6 clk = ~clk;

  // Shadow copy of the interface registers.
  logic [47:0] my_mac;
  logic [31:0] my_ip;
  logic [14:0] hold_ms;
  logic [14:0] life_ms;

  // Shadow copy of the resolution table.
  bit          sh_valid [SLOTS];
  logic [31:0] sh_ip    [SLOTS];
  logic [47:0] sh_mac   [SLOTS];
  bit          sh_res   [SLOTS];
  logic [14:0] sh_left  [SLOTS];
  bit          sh_wait  [SLOTS];
  logic [15:0] sh_whdl  [SLOTS];

  frame_t      frames_due[$];
  int          n_items, n_frames, n_errors, n_requests, n_replies, n_deliv, n_ipv4;
  int          idle_cycles;
  logic [31:0] ip_pool [IP_POOL];

  function automatic void add_frame(logic [1:0] kind, logic [47:0] dst, logic [31:0] tip,
                                    logic [47:0] tmac, logic [15:0] hdl);
    frame_t f;
    f.r.kind   = kind;
    f.r.dst    = dst;
    f.r.tip    = tip;
    f.r.tmac   = tmac;
    f.r.handle = hdl;
    f.last     = 1'b0;
    frames_due.push_back(f);
  endfunction

  // Resolve one accepted item against the shadow table; queue the frames it causes.
  function automatic void resolve_item(cmd_t c);
    int hit;
    int fr;
    int n0;
    hit = -1;
    fr  = -1;
    n0  = frames_due.size();
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (sh_valid[i] && sh_ip[i] == c.peer) hit = i;
      if (!sh_valid[i]) fr = i;
    end
    case (c.op)
      art_pkg::OP_SEND: begin
        if (hit >= 0) begin
          if (sh_res[hit]) add_frame(art_pkg::KIND_IPV4, sh_mac[hit], '0, '0, c.hdl);
        end else begin
          add_frame(art_pkg::KIND_REQUEST, art_pkg::MAC_BCAST, c.peer, '0, '0);
          if (fr >= 0) begin
            sh_valid[fr] = 1;  sh_ip[fr] = c.peer;  sh_mac[fr] = '0;
            sh_res[fr] = 0;    sh_left[fr] = hold_ms;
            sh_wait[fr] = 1;   sh_whdl[fr] = c.hdl;
          end
        end
      end
      art_pkg::OP_ARP: begin
        if (c.ok) begin
          if (hit < 0 && fr >= 0) begin
            hit = fr;
            sh_valid[hit] = 1;  sh_ip[hit] = c.peer;
            sh_wait[hit] = 0;   sh_whdl[hit] = '0;
          end
          if (hit >= 0) begin
            sh_mac[hit] = c.smac;  sh_res[hit] = 1;  sh_left[hit] = life_ms;
            if (sh_wait[hit]) begin
              add_frame(art_pkg::KIND_IPV4, c.smac, '0, '0, sh_whdl[hit]);
              sh_wait[hit] = 0;
            end
          end
          if (c.is_req && c.asked == my_ip)
            add_frame(art_pkg::KIND_REPLY, c.smac, c.peer, c.smac, '0);
        end
      end
      art_pkg::OP_IPV4: begin
        if (c.ok && c.fdst == my_mac)
          add_frame(art_pkg::KIND_DELIVER, '0, '0, '0, c.hdl);
      end
      default: begin
        // aging: entries whose time runs out are dropped with their held datagram
        for (int i = 0; i < SLOTS; i++) begin
          if (sh_valid[i]) begin
            if ({1'b0, sh_left[i]} > c.elapsed) sh_left[i] = sh_left[i] - c.elapsed[14:0];
            else begin
              sh_valid[i] = 0;
              sh_wait[i]  = 0;
            end
          end
        end
      end
    endcase
    if (frames_due.size() > n0) frames_due[frames_due.size() - 1].last = 1'b1;
  endfunction

  // Result checker: the receiver cannot stall, so every strobe is consumed here.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      n_frames++;
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected frame kind=%0d dst=%h", $time, frame_kind, dest_mac);
        n_errors++;
      end else begin
        frame_t e;
        e = frames_due.pop_front();
        if (frame_kind !== e.r.kind) begin
          $display("%0t: frame_kind exp %0d got %0d", $time, e.r.kind, frame_kind);
          n_errors++;
        end
        if (dest_mac !== e.r.dst) begin
          $display("%0t: dest_mac exp %h got %h", $time, e.r.dst, dest_mac);
          n_errors++;
        end
        if (arp_target_ip !== e.r.tip) begin
          $display("%0t: arp_target_ip exp %h got %h", $time, e.r.tip, arp_target_ip);
          n_errors++;
        end
        if (arp_target_mac !== e.r.tmac) begin
          $display("%0t: arp_target_mac exp %h got %h", $time, e.r.tmac, arp_target_mac);
          n_errors++;
        end
        if (out_handle !== e.r.handle) begin
          $display("%0t: out_handle exp %h got %h", $time, e.r.handle, out_handle);
          n_errors++;
        end
        if (last_result !== e.last) begin
          $display("%0t: last_result exp %0b got %0b", $time, e.last, last_result);
          n_errors++;
        end
        case (e.r.kind)
          art_pkg::KIND_IPV4:    n_ipv4++;
          art_pkg::KIND_REQUEST: n_requests++;
          art_pkg::KIND_REPLY:   n_replies++;
          default:               n_deliv++;
        endcase
      end
    end
  end

  // Watchdog: counts cycles where neither an item nor a frame moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("%0t: watchdog expired, %0d frames outstanding", $time, frames_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drive one item after an optional gap; returns at the edge it is taken.
  task automatic send_item(cmd_t c, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation <= c.op;          peer_ip <= c.peer;
    sender_mac <= c.smac;       frame_dst_mac <= c.fdst;
    asked_ip <= c.asked;        arp_is_request <= c.is_req;
    parse_ok <= c.ok;           datagram_handle <= c.hdl;
    elapsed_ms <= c.elapsed;    start <= 1'b1;
    do @(posedge clk); while (busy);
    n_items++;
  endtask

  // Quiesce, then write all four registers back to back.
  task automatic write_regs(logic [47:0] mac, logic [31:0] ip, logic [14:0] hold,
                            logic [14:0] life);
    start <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    // items that produce nothing may still be sweeping
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;  cfg_index <= art_pkg::REG_OWN_MAC;  cfg_data <= mac;
    @(posedge clk);
    cfg_index <= art_pkg::REG_OWN_IP;  cfg_data <= {16'd0, ip};
    @(posedge clk);
    cfg_index <= art_pkg::REG_HOLD;  cfg_data <= {33'd0, hold};
    @(posedge clk);
    cfg_index <= art_pkg::REG_LIFE;  cfg_data <= {33'd0, life};
    @(posedge clk);
    cfg_we <= 1'b0;
    my_mac = mac;  my_ip = ip;  hold_ms = hold;  life_ms = life;
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom()), $urandom()};
  endfunction

  function automatic cmd_t mk(logic [1:0] op, logic [31:0] peer, logic [47:0] smac,
                              logic [47:0] fdst, logic [31:0] asked, logic is_req,
                              logic ok, logic [15:0] hdl, logic [15:0] elapsed);
    cmd_t c;
    c.op = op;  c.peer = peer;  c.smac = smac;  c.fdst = fdst;  c.asked = asked;
    c.is_req = is_req;  c.ok = ok;  c.hdl = hdl;  c.elapsed = elapsed;
    return c;
  endfunction

  function automatic frame_t fr(logic [1:0] kind, logic [47:0] dst, logic [31:0] tip,
                                logic [47:0] tmac, logic [15:0] hdl);
    frame_t f;
    f.r.kind = kind;  f.r.dst = dst;  f.r.tip = tip;  f.r.tmac = tmac;  f.r.handle = hdl;
    f.last = 1'b1;
    return f;
  endfunction

  // Random item: mostly send/learn traffic over a small address pool so that
  // lookups hit, pending entries get answered and the table fills up.
  function automatic cmd_t rand_item();
    cmd_t c;
    int   sel;
    sel = $urandom_range(0, 99);
    c = mk(art_pkg::OP_SEND, ip_pool[$urandom_range(0, IP_POOL - 1)], rand48(), rand48(),
           $urandom(), 1'($urandom_range(0, 1)), ($urandom_range(0, 9) != 0),
           16'($urandom_range(0, 65535)), '0);
    if ($urandom_range(0, 19) == 0) c.peer = $urandom();
    if (sel < 35)      c.op = art_pkg::OP_SEND;
    else if (sel < 65) c.op = art_pkg::OP_ARP;
    else if (sel < 80) c.op = art_pkg::OP_IPV4;
    else               c.op = art_pkg::OP_TICK;
    if ($urandom_range(0, 1)) c.asked = my_ip;
    if ($urandom_range(0, 2) != 0) c.fdst = my_mac;
    sel = $urandom_range(0, 9);
    if (sel < 6)       c.elapsed = 16'($urandom_range(0, 300));
    else if (sel < 9)  c.elapsed = 16'($urandom_range(0, 40000));
    else               c.elapsed = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom());
    return c;
  endfunction

  initial begin
    row_t        rows[$];
    row_t        rw;
    frame_t      none;
    int          n0;
    bit          burst;
    logic [47:0] mac_a;
    none = fr(art_pkg::KIND_IPV4, '0, '0, '0, '0);
    mac_a = 48'h1122_3344_5566;
    my_mac = '0;  my_ip = '0;  hold_ms = art_pkg::HOLD_RESET;  life_ms = art_pkg::LIFE_RESET;
    foreach (sh_valid[i]) sh_valid[i] = 0;
    foreach (ip_pool[i]) ip_pool[i] = $urandom();
    ip_pool[0] = '0;
    ip_pool[1] = '1;

    // Directed rows, run with the reset register values (own MAC and IP zero).
    rows.push_back('{mk(art_pkg::OP_IPV4, '0, '0, '0, '0, 0, 1, 16'hFFFF, '0), 1, 1,
                     fr(art_pkg::KIND_DELIVER, '0, '0, '0, 16'hFFFF)});
    rows.push_back('{mk(art_pkg::OP_IPV4, '0, '0, '0, '0, 0, 0, 16'h0001, '0), 1, 0, none});
    rows.push_back('{mk(art_pkg::OP_IPV4, '0, '0, '1, '0, 0, 1, 16'h0002, '0), 1, 0, none});
    rows.push_back('{mk(art_pkg::OP_SEND, 32'h0A00_0001, '0, '0, '0, 0, 0, 16'h1234, '0),
                     1, 1,
                     fr(art_pkg::KIND_REQUEST, art_pkg::MAC_BCAST, 32'h0A00_0001, '0, '0)});
    // pending next hop: datagram dropped
    rows.push_back('{mk(art_pkg::OP_SEND, 32'h0A00_0001, '0, '0, '0, 0, 1, 16'h0005, '0),
                     1, 0, none});
    // answer releases the held datagram once
    rows.push_back('{mk(art_pkg::OP_ARP, 32'h0A00_0001, mac_a, '0, 32'h0101_0101, 0, 1,
                        '0, '0), 1, 1,
                     fr(art_pkg::KIND_IPV4, mac_a, '0, '0, 16'h1234)});
    rows.push_back('{mk(art_pkg::OP_ARP, 32'h0A00_0001, mac_a, '0, 32'h0101_0101, 0, 1,
                        '0, '0), 1, 0, none});
    rows.push_back('{mk(art_pkg::OP_SEND, 32'h0A00_0001, '0, '0, '0, 0, 1, 16'h0000, '0),
                     1, 1, fr(art_pkg::KIND_IPV4, mac_a, '0, '0, 16'h0000)});
    rows.push_back('{mk(art_pkg::OP_ARP, '1, '1, '0, '0, 1, 1, 16'hFFFF, '0), 1, 1,
                     fr(art_pkg::KIND_REPLY, '1, '1, '1, '0)});
    rows.push_back('{mk(art_pkg::OP_ARP, 32'h0B00_0001, '1, '0, '0, 1, 0, '0, '0), 1, 0,
                     none});
    rows.push_back('{mk(art_pkg::OP_SEND, '0, '0, '0, '0, 0, 1, 16'h00AA, '0), 1, 1,
                     fr(art_pkg::KIND_REQUEST, art_pkg::MAC_BCAST, '0, '0, '0)});
    // pending entry answered by a request for our IP: forward then reply
    rows.push_back('{mk(art_pkg::OP_ARP, '0, 48'h8000_0000_0001, '0, '0, 1, 1, '0, '0), 0, 0,
                     none});
    rows.push_back('{mk(art_pkg::OP_TICK, '0, '0, '0, '0, 0, 0, '0, 16'd0), 1, 0, none});
    rows.push_back('{mk(art_pkg::OP_TICK, '0, '0, '0, '0, 0, 0, '0, 16'd29999), 1, 0, none});
    rows.push_back('{mk(art_pkg::OP_SEND, '1, '0, '0, '0, 0, 1, 16'h0007, '0), 0, 0, none});
    rows.push_back('{mk(art_pkg::OP_TICK, '0, '0, '0, '0, 0, 0, '0, 16'hFFFF), 1, 0, none});
    // everything expired: a known address is unknown again
    rows.push_back('{mk(art_pkg::OP_SEND, 32'h0A00_0001, '0, '0, '0, 0, 1, 16'h0009, '0),
                     1, 1,
                     fr(art_pkg::KIND_REQUEST, art_pkg::MAC_BCAST, 32'h0A00_0001, '0, '0)});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      rw = rows[i];
      send_item(rw.c, $urandom_range(0, 7));
      n0 = frames_due.size();
      resolve_item(rw.c);
      if (rw.fixed) begin
        while (frames_due.size() > n0) void'(frames_due.pop_back());
        if (rw.has_res) frames_due.push_back(rw.res);
      end
    end

    // Random phases, each after a register change; extremes first.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_regs('1, '1, 15'd1, 15'd1);
        1: write_regs('0, '0, 15'd32767, 15'd32767);
        2: write_regs(rand48(), $urandom(), 15'd1, 15'd32767);
        default: write_regs(rand48(), $urandom(), 15'($urandom_range(1, 32767)),
                            15'($urandom_range(1, 32767)));
      endcase
      for (int k = 0; k < 400; k++) begin
        if (k % 50 == 0) burst = ($urandom_range(0, 3) == 0);
        begin
          cmd_t c;
          c = rand_item();
          send_item(c, burst ? 0 : $urandom_range(0, 7));
          resolve_item(c);
        end
      end
    end

    start <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE + 16) @(posedge clk);
    if (frames_due.size() != 0) begin
      $display("%0t: %0d frames never arrived", $time, frames_due.size());
      n_errors++;
    end
    $display("Covered %0d items over 5 register settings, %0d frames checked:", n_items,
             n_frames);
    $display("  %0d IPv4 out, %0d requests, %0d replies, %0d deliveries, %0d errors",
             n_ipv4, n_requests, n_replies, n_deliv, n_errors);
    if (n_errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
src/art_pkg.sv
src/art_ram.sv
src/arp_resolution_table_core.sv
bench/tb_arp_resolution_table_core.sv
